// File: design/hkrb_pkg.sv
// Shared constants, types and the keycode ROM for the HID keyboard report builder.
package hkrb_pkg;

    localparam int MATRIX_ROWS = 8;
    localparam int MATRIX_COLS = 13;
    localparam int SLOT_COUNT  = 6;

    localparam int ROM_ROWS   = 8;
    localparam int ROM_COLS   = 13;
    localparam int OUT_SLOTS  = 6;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SHOWN_SLOTS = (SLOT_COUNT < OUT_SLOTS) ? SLOT_COUNT : OUT_SLOTS;

    localparam logic [7:0] MOD_FIRST   = 8'he0;
    localparam logic [7:0] MOD_LAST    = 8'he7;
    localparam logic [7:0] EXTRA_FIRST = 8'hf0;
    localparam logic [7:0] EXTRA_LAST  = 8'hf1;
    localparam logic [1:0] EXTRA_MASK  = 2'h3;

    localparam logic [2:0] REG_BOOT_MODE = 3'd0;

    typedef logic [SLOT_COUNT-1:0][7:0] t_slot_arr;
    typedef logic [OUT_SLOTS-1:0][7:0]  t_out_slots;

    // slot file command from the sequencer
    typedef struct packed {
        logic                  wr;
        logic [SLOT_IDX_W-1:0] idx;
        logic [7:0]            code;
        logic [7:0]            wdata;
    } t_slot_cmd;

    // compare result for the addressed slot
    typedef struct packed {
        logic match;
        logic empty;
    } t_slot_stat;

    // one 64-bit word per matrix column, row 0 in the low byte
    function automatic logic [63:0] rom_column(input logic [3:0] col);
        logic [63:0] w;
        case (col)
            4'd0:    w = 64'h0000f0e4e3e00000;
            4'd1:    w = 64'h141e1d04352b29e3;
            4'd2:    w = 64'h082006073b3c3d3a;
            4'd3:    w = 64'h1521190922170a05;
            4'd4:    w = 64'h1a1f1b163e3f4043;
            4'd5:    w = 64'h0c25360e00300087;
            4'd6:    w = 64'h1824100d231c0b11;
            4'd7:    w = 64'he500e10000640000;
            4'd8:    w = 64'h132738332d2f342e;
            4'd9:    w = 64'h1226370f68414200;
            4'd10:   w = 64'h00e20031008900e6;
            4'd11:   w = 64'h52512c2831002a00;
            4'd12:   w = 64'h504f00008b008a00;
            default: w = 64'h0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] lookup_code(input logic [2:0] row, input logic [3:0] col);
        logic [63:0] w;
        logic        off;
        w   = rom_column(col);
        off = ({1'b0, row} >= 4'(MATRIX_ROWS)) || ({2'b0, col} >= 6'(MATRIX_COLS))
              || ({1'b0, col} >= 5'(ROM_COLS));
        return off ? 8'h00 : w[{row, 3'b000} +: 8];
    endfunction

endpackage

// File: design/hkrb_ifs.sv
// Valid/ready channel interfaces for key events and keyboard reports.
interface hkrb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_row;
    logic [3:0] key_col;
    logic       pressed;

    modport source (output valid, output key_row, output key_col, output pressed,
                    input ready);
    modport sink   (input valid, input key_row, input key_col, input pressed,
                    output ready);
endinterface

interface hkrb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] slot_code_0;
    logic [7:0] slot_code_1;
    logic [7:0] slot_code_2;
    logic [7:0] slot_code_3;
    logic [7:0] slot_code_4;
    logic [7:0] slot_code_5;
    logic [1:0] switch_bits;

    modport source (output valid, output byte_zero, output byte_one,
                    output slot_code_0, output slot_code_1, output slot_code_2,
                    output slot_code_3, output slot_code_4, output slot_code_5,
                    output switch_bits, input ready);
    modport sink   (input valid, input byte_zero, input byte_one,
                    input slot_code_0, input slot_code_1, input slot_code_2,
                    input slot_code_3, input slot_code_4, input slot_code_5,
                    input switch_bits, output ready);
endinterface

// File: design/hkrb_slot_file.sv
// Key slot registers with one shared compare unit on the addressed slot.
module hkrb_slot_file (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hkrb_pkg::t_slot_cmd i_cmd,
    output hkrb_pkg::t_slot_stat o_stat,
    output hkrb_pkg::t_slot_arr o_slots
);

    hkrb_pkg::t_slot_arr r_slots;
    logic [7:0]          slot_q;

    assign slot_q       = r_slots[i_cmd.idx];
    assign o_stat.match = (slot_q == i_cmd.code);
    assign o_stat.empty = (slot_q == 8'h00);
    assign o_slots      = r_slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else if (i_cmd.wr) begin
            r_slots[i_cmd.idx] <= i_cmd.wdata;
        end
    end

endmodule

// File: design/hid_keyboard_report_builder_core.sv
// Top level: key event sequencer, modifier and switch state, report register, APB port.
// Modifier and switch keys go from accept through the lookup and classify states to
//   the report state; ordinary keys go through the slot scan (one slot per cycle through
//   the shared compare unit) and reach it only if a slot changes. The report state holds
//   while the last report waits. One event in flight; ready again once back in idle.
// Reset (synchronous, active low) clears modifiers, switch bits, slots, boot_mode,
//   and the output valid.
module hid_keyboard_report_builder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hkrb_in_if.sink     i_in,
    hkrb_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLASSIFY,
        ST_SCAN,
        ST_REPORT
    } t_state;

    t_state                         r_state, n_state;
    logic [2:0]                     r_row, n_row;
    logic [3:0]                     r_col, n_col;
    logic                           r_pressed, n_pressed;
    logic [7:0]                     r_code, n_code;
    logic [hkrb_pkg::SLOT_IDX_W-1:0] r_idx, n_idx;
    logic [7:0]                     r_mod, n_mod;
    logic [1:0]                     r_extra, n_extra;
    logic                           r_boot, n_boot;
    logic                           r_out_valid, n_out_valid;
    logic [7:0]                     r_byte0, n_byte0;
    logic [7:0]                     r_byte1, n_byte1;
    hkrb_pkg::t_out_slots           r_oslots, n_oslots;
    logic [1:0]                     r_oswitch, n_oswitch;

    hkrb_pkg::t_slot_cmd  slot_cmd;
    hkrb_pkg::t_slot_stat slot_stat;
    hkrb_pkg::t_slot_arr  slots;
    hkrb_pkg::t_out_slots slot_view;
    logic                 is_mod, is_extra, last_slot, cfg_wr;
    logic [7:0]           mod_mask;
    logic [1:0]           extra_mask;

    hkrb_slot_file u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (slot_cmd),
        .o_stat  (slot_stat),
        .o_slots (slots)
    );

    assign is_mod     = (r_code >= hkrb_pkg::MOD_FIRST) && (r_code <= hkrb_pkg::MOD_LAST);
    assign is_extra   = (r_code >= hkrb_pkg::EXTRA_FIRST) && (r_code <= hkrb_pkg::EXTRA_LAST);
    assign mod_mask   = 8'h01 << r_code[2:0];
    assign extra_mask = 2'h1 << r_code[0];
    assign last_slot  = (r_idx == hkrb_pkg::SLOT_IDX_W'(hkrb_pkg::SLOT_COUNT - 1));
    assign cfg_wr     = psel && penable && pwrite && pready;

    assign i_in.ready = (r_state == ST_IDLE);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == hkrb_pkg::REG_BOOT_MODE[2]) ? {31'b0, r_boot} : 32'b0;

    assign o_out.valid       = r_out_valid;
    assign o_out.byte_zero   = r_byte0;
    assign o_out.byte_one    = r_byte1;
    assign o_out.slot_code_0 = r_oslots[0];
    assign o_out.slot_code_1 = r_oslots[1];
    assign o_out.slot_code_2 = r_oslots[2];
    assign o_out.slot_code_3 = r_oslots[3];
    assign o_out.slot_code_4 = r_oslots[4];
    assign o_out.slot_code_5 = r_oslots[5];
    assign o_out.switch_bits = r_oswitch;

    // pad the slot file out to the six report fields
    always_comb begin
        slot_view = '0;
        for (int j = 0; j < hkrb_pkg::SHOWN_SLOTS; j++) begin
            slot_view[j] = slots[j];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_pressed   = r_pressed;
        n_code      = r_code;
        n_idx       = r_idx;
        n_mod       = r_mod;
        n_extra     = r_extra;
        n_boot      = r_boot;
        n_out_valid = r_out_valid;
        n_byte0     = r_byte0;
        n_byte1     = r_byte1;
        n_oslots    = r_oslots;
        n_oswitch   = r_oswitch;

        slot_cmd.wr    = 1'b0;
        slot_cmd.idx   = r_idx;
        slot_cmd.code  = r_code;
        slot_cmd.wdata = 8'h00;

        if (cfg_wr && (paddr[2] == hkrb_pkg::REG_BOOT_MODE[2])) begin
            n_boot = pwdata[0];
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_row     = i_in.key_row;
                    n_col     = i_in.key_col;
                    n_pressed = i_in.pressed;
                    n_state   = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_code  = hkrb_pkg::lookup_code(r_row, r_col);
                n_state = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                n_idx = '0;
                if (r_code == 8'h00) begin
                    n_state = ST_IDLE;
                end else if (is_extra) begin
                    n_extra = (r_pressed ? (r_extra | extra_mask) : (r_extra & ~extra_mask))
                              & hkrb_pkg::EXTRA_MASK;
                    n_state = ST_REPORT;
                end else if (is_mod) begin
                    n_mod   = r_pressed ? (r_mod | mod_mask) : (r_mod & ~mod_mask);
                    n_state = ST_REPORT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_pressed) begin
                    if (slot_stat.match) begin
                        n_state = ST_IDLE;
                    end else if (slot_stat.empty) begin
                        slot_cmd.wr    = 1'b1;
                        slot_cmd.wdata = r_code;
                        n_state        = ST_REPORT;
                    end else if (last_slot) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (slot_stat.match) begin
                        slot_cmd.wr = 1'b1;
                        n_state     = ST_REPORT;
                    end else if (last_slot) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_REPORT: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_byte0     = r_boot ? r_mod : 8'h00;
                    n_byte1     = r_boot ? 8'h00 : r_mod;
                    n_oslots    = slot_view;
                    n_oswitch   = r_extra;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mod       <= 8'h00;
            r_extra     <= 2'b00;
            r_boot      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mod       <= n_mod;
            r_extra     <= n_extra;
            r_boot      <= n_boot;
            r_out_valid <= n_out_valid;
        end
        r_row     <= n_row;
        r_col     <= n_col;
        r_pressed <= n_pressed;
        r_code    <= n_code;
        r_idx     <= n_idx;
        r_byte0   <= n_byte0;
        r_byte1   <= n_byte1;
        r_oslots  <= n_oslots;
        r_oswitch <= n_oswitch;
    end

endmodule

// File: design/hkrb_checker.sv
// Port-level assertions for the report builder, bound to the top level.
module hkrb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_byte_zero,
    input logic [7:0] i_byte_one,
    input logic [7:0] i_slot_code_0,
    input logic [1:0] i_switch_bits
);

    // a stalled word holds its header bytes, first slot code and switch bits
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_byte_zero)
            && $stable(i_byte_one) && $stable(i_slot_code_0) && $stable(i_switch_bits))
        else $error("stalled report word changed");

    // busy while a key event is being worked on
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before the event finished");

    // modifiers land in at most one of the two header bytes
    a_layout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_byte_zero == 8'h00) || (i_byte_one == 8'h00))
        else $error("both header bytes nonzero");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

endmodule

bind hid_keyboard_report_builder_core hkrb_checker u_hkrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_byte_zero   (o_out.byte_zero),
    .i_byte_one    (o_out.byte_one),
    .i_slot_code_0 (o_out.slot_code_0),
    .i_switch_bits (o_out.switch_bits)
);
